@@ sv/smbi_pkg.sv @@
package smbi_pkg;

   localparam int DEPTH  = 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam int MODE_W     = 2;
   localparam int VALUE_W    = 64;
   localparam int IDX_W      = 8;
   localparam int POS_W      = 8;
   localparam int COUNT_W    = 9;
   localparam int STATUS_W   = 2;
   localparam int IDX_EXT_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   localparam int REQ_DATA_W = ((VALUE_W + IDX_W + 7) / 8) * 8;
   localparam int RSP_FLD_W  = VALUE_W + POS_W + COUNT_W + STATUS_W;
   localparam int RSP_DATA_W = ((RSP_FLD_W + 7) / 8) * 8;

   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

@@ sv/smbi_ram.sv @@
module smbi_ram (
   input  logic                         clock,
   input  smbi_pkg::ram_req_type        ram_req,
   input  logic [smbi_pkg::VALUE_W-1:0] wr_data,
   output logic [smbi_pkg::VALUE_W-1:0] rd_data
);
   import smbi_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data <= mem[ram_req.rd_addr];
      end
   end

endmodule

@@ sv/sorted_merge_by_insertion_top.sv @@
// Store of signed 64-bit values, kept in order by binary insertion; an append
// goes to the end unchecked. The request channel carries one word per
// operation: tuser holds the mode (append, insert or read; any other mode
// changes nothing and returns status OK) and tdata holds the value and the
// read index. Every request yields exactly one response word with the read
// value, the placement position, the entry count after the operation and a
// status code. Requests are handled one at a time. An append passes through
// the dispatch and finish states, a read through dispatch, read wait and
// finish. An insert runs a binary search of about log2(count + 1) probes,
// each an issue and a compare state, on the store with one read port and one
// write port. It then moves the entries above the insertion point up by one
// at one entry per cycle. The next request is accepted in the cycle after the
// response is loaded. An append or insert into a full store or a read index at
// or beyond the count returns an error status and leaves the store unchanged.
// A synchronous reset empties the store at once by clearing the entry count;
// no clearing pass is needed.
// The response sits in an output register, so a new request is taken while an
// earlier response is still waiting; when the receiver stalls, the block holds
// its next finished response until the waiting one has been taken.
module sorted_merge_by_insertion_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // value [63:0], index [71:64]
   input  logic [smbi_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode [1:0]
   input  logic [smbi_pkg::MODE_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_value [63:0], position [71:64], stored_count [80:72], status [82:81]
   output logic [smbi_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import smbi_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ_WAIT,
      ST_SEARCH_ISSUE,
      ST_SEARCH_CMP,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   state_type             state_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic [VALUE_W-1:0]    value_ff;
   logic [IDX_W-1:0]      index_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      lo_ff;
   logic [CNT_W-1:0]      hi_ff;
   logic [CNT_W-1:0]      src_ff;
   logic                  pend_ff;
   logic [VALUE_W-1:0]    res_read_ff;
   logic [CNT_W-1:0]      res_pos_ff;
   logic [STATUS_W-1:0]   res_status_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   ram_req_type           ram_req;
   logic [VALUE_W-1:0]    ram_wr_data;
   logic [VALUE_W-1:0]    ram_rd_data;

   logic [CNT_W:0]        lo_hi_sum;
   logic [CNT_W-1:0]      mid;
   logic                  full;
   logic                  index_bad;
   logic                  src_above;
   logic                  req_accept;
   logic                  rsp_load;

   assign lo_hi_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = lo_hi_sum[CNT_W:1];
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign index_bad  = (IDX_EXT_W'(index_ff) >= IDX_EXT_W'(count_ff));
   assign src_above  = (src_ff > lo_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      ram_req     = '0;
      ram_wr_data = value_ff;
      unique case (state_ff)
         ST_DISPATCH: begin
            if (mode_ff == MODE_APPEND && !full) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = count_ff[ADDR_W-1:0];
            end
            if (mode_ff == MODE_READ && !index_bad) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = ADDR_W'(index_ff);
            end
         end
         ST_SEARCH_ISSUE: begin
            ram_req.rd_en   = (lo_ff < hi_ff);
            ram_req.rd_addr = mid[ADDR_W-1:0];
         end
         ST_SHIFT: begin
            ram_req.rd_en   = src_above;
            ram_req.rd_addr = ADDR_W'(src_ff - CNT_W'(1));
            if (pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = ADDR_W'(src_ff + CNT_W'(1));
               ram_wr_data     = ram_rd_data;
            end else if (!src_above) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = lo_ff[ADDR_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   smbi_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  mode_ff  <= req_tuser;
                  value_ff <= req_tdata[VALUE_W-1:0];
                  index_ff <= req_tdata[VALUE_W+IDX_W-1:VALUE_W];
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               res_read_ff <= '0;
               unique case (mode_ff)
                  MODE_APPEND: begin
                     state_ff <= ST_FINISH;
                     if (full) begin
                        res_pos_ff    <= '0;
                        res_status_ff <= STATUS_FULL;
                     end else begin
                        res_pos_ff    <= count_ff;
                        res_status_ff <= STATUS_OK;
                        count_ff      <= count_ff + CNT_W'(1);
                     end
                  end
                  MODE_INSERT: begin
                     res_pos_ff <= '0;
                     if (full) begin
                        res_status_ff <= STATUS_FULL;
                        state_ff      <= ST_FINISH;
                     end else begin
                        res_status_ff <= STATUS_OK;
                        lo_ff         <= '0;
                        hi_ff         <= count_ff;
                        state_ff      <= ST_SEARCH_ISSUE;
                     end
                  end
                  MODE_READ: begin
                     res_pos_ff <= '0;
                     if (index_bad) begin
                        res_status_ff <= STATUS_RANGE;
                        state_ff      <= ST_FINISH;
                     end else begin
                        res_status_ff <= STATUS_OK;
                        state_ff      <= ST_READ_WAIT;
                     end
                  end
                  default: begin
                     res_pos_ff    <= '0;
                     res_status_ff <= STATUS_OK;
                     state_ff      <= ST_FINISH;
                  end
               endcase
            end
            ST_READ_WAIT: begin
               res_read_ff <= ram_rd_data;
               state_ff    <= ST_FINISH;
            end
            ST_SEARCH_ISSUE: begin
               if (lo_ff < hi_ff) begin
                  state_ff <= ST_SEARCH_CMP;
               end else begin
                  src_ff   <= count_ff;
                  pend_ff  <= 1'b0;
                  state_ff <= ST_SHIFT;
               end
            end
            ST_SEARCH_CMP: begin
               if ($signed(ram_rd_data) < $signed(value_ff)) begin
                  lo_ff <= mid + CNT_W'(1);
               end else begin
                  hi_ff <= mid;
               end
               state_ff <= ST_SEARCH_ISSUE;
            end
            ST_SHIFT: begin
               pend_ff <= src_above;
               if (src_above) begin
                  src_ff <= src_ff - CNT_W'(1);
               end else if (!pend_ff) begin
                  res_pos_ff <= lo_ff;
                  count_ff   <= count_ff + CNT_W'(1);
                  state_ff   <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_load) begin
                  rsp_data_ff  <= RSP_DATA_W'({res_status_ff, COUNT_W'(count_ff),
                                               POS_W'(res_pos_ff), res_read_ff});
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Entry count exceeds the store depth.");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff))
         |-> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("Entry count changed by other than one.");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH_ISSUE || state_ff == ST_SEARCH_CMP)
         |-> (lo_ff <= hi_ff && hi_ff <= count_ff))
      else $error("Binary search bounds out of order.");

   a_shift_above: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && pend_ff) |-> (src_ff >= lo_ff && src_ff < count_ff))
      else $error("Shift writes at or below the insertion point.");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res_status_ff == STATUS_FULL) |-> full)
      else $error("Full status reported while the store has room.");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import smbi_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 20000;
   localparam int RANDOM_WORDS = 400;
   localparam int TAIL_CYCLES  = 300;

   typedef struct {
      logic [VALUE_W-1:0]  read_value;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  stored_count;
      logic [STATUS_W-1:0] status;
   } rsp_fields_type;

   class sorted_store_checker_type;
      logic [VALUE_W-1:0] entries [DEPTH];
      int unsigned held;
      rsp_fields_type awaited [$];
      int unsigned errors;

      function new();
         held = 0;
         errors = 0;
      endfunction

      function int unsigned lower_bound(logic [VALUE_W-1:0] v);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = held;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if ($signed(entries[mid]) < $signed(v)) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         return lo;
      endfunction

      function void accept_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                                   logic [IDX_W-1:0] index);
         rsp_fields_type want;
         int unsigned slot;
         int unsigned i;
         want.read_value = '0;
         want.position = '0;
         want.status = STATUS_OK;
         if (mode == MODE_APPEND || mode == MODE_INSERT) begin
            if (held >= DEPTH) begin
               want.status = STATUS_FULL;
            end else begin
               slot = (mode == MODE_APPEND) ? held : lower_bound(value);
               for (i = held; i > slot; i--) begin
                  entries[i] = entries[i - 1];
               end
               entries[slot] = value;
               held++;
               want.position = slot[POS_W-1:0];
            end
         end else if (mode == MODE_READ) begin
            if (index >= held) begin
               want.status = STATUS_RANGE;
            end else begin
               want.read_value = entries[index];
            end
         end
         want.stored_count = held[COUNT_W-1:0];
         awaited = {awaited, want};
      endfunction

      function void match_response(logic [RSP_DATA_W-1:0] word);
         rsp_fields_type want;
         rsp_fields_type got;
         got.read_value   = word[VALUE_W-1:0];
         got.position     = word[VALUE_W +: POS_W];
         got.stored_count = word[VALUE_W+POS_W +: COUNT_W];
         got.status       = word[VALUE_W+POS_W+COUNT_W +: STATUS_W];
         if (awaited.size() == 0) begin
            $error("response word arrived with no request pending");
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
            errors++;
         end
         if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            errors++;
         end
         if (got.stored_count !== want.stored_count) begin
            $error("stored_count: expected %0d, actual %0d", want.stored_count,
                   got.stored_count);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   sorted_store_checker_type chk = new();
   int unsigned send_idle_pct = 10;
   int unsigned recv_idle_pct = 85;
   int unsigned quiet_cycles = 0;
   logic [VALUE_W-1:0] last_append = 64'hF000_0000_0000_0000;

   sorted_merge_by_insertion_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         chk.match_response(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                            logic [IDX_W-1:0] index);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {index, value};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      chk.accept_request(mode, value, index);
      @(negedge clock);
   endtask

   task automatic send_random_word();
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
      logic [IDX_W-1:0]   index;
      int unsigned pick;
      pick  = $urandom_range(0, 99);
      value = {$urandom(), $urandom()};
      index = IDX_W'($urandom_range(0, 255));
      if (chk.held < DEPTH) begin
         if (pick < 35) begin
            mode = MODE_APPEND;
            if ($urandom_range(0, 9) != 0) begin
               value = last_append + 64'($urandom_range(0, 65535));
            end
            last_append = value;
         end else if (pick < 70) begin
            mode = MODE_INSERT;
            if (chk.held != 0 && $urandom_range(0, 4) == 0) begin
               value = chk.entries[$urandom_range(0, chk.held - 1)];
            end else if ($urandom_range(0, 1) == 0) begin
               value = 64'($urandom_range(0, 2000)) - 64'd1000;
            end
         end else if (pick < 95) begin
            mode = MODE_READ;
            if (chk.held != 0 && $urandom_range(0, 4) != 0) begin
               index = IDX_W'($urandom_range(0, chk.held - 1));
            end
         end else begin
            mode = MODE_UNUSED;
         end
      end else begin
         if (pick < 60) begin
            mode = MODE_READ;
         end else if (pick < 78) begin
            mode = MODE_APPEND;
         end else if (pick < 95) begin
            mode = MODE_INSERT;
         end else begin
            mode = MODE_UNUSED;
         end
      end
      send_word(mode, value, index);
   endtask

   task automatic send_random_words(int unsigned count);
      repeat (count) send_random_word();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(MODE_READ,   64'd7, 8'd0);
      send_word(MODE_READ,   '1, 8'd255);
      send_word(MODE_INSERT, 64'd5, 8'd0);
      send_word(MODE_INSERT, 64'h8000_0000_0000_0000, 8'd0);
      send_word(MODE_APPEND, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0);
      send_word(MODE_INSERT, 64'd5, 8'd0);
      send_word(MODE_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0);
      send_word(MODE_INSERT, 64'd0, 8'd255);
      send_word(MODE_APPEND, 64'h8000_0000_0000_0000, 8'd0);
      send_word(MODE_INSERT, 64'd3, 8'd0);
      send_word(MODE_INSERT, '1, 8'd0);
      send_word(MODE_UNUSED, '1, 8'd255);
      send_word(MODE_READ,   64'd0, 8'd0);
      send_word(MODE_READ,   64'd0, 8'd9);
      send_word(MODE_READ,   64'd0, 8'd10);
      send_word(MODE_READ,   64'd0, 8'd4);
      send_word(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFFE, 8'd0);
      send_word(MODE_READ,   64'd0, 8'd10);

      send_random_words(RANDOM_WORDS);
      send_idle_pct = 85;
      recv_idle_pct = 10;
      send_random_words(RANDOM_WORDS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_words(RANDOM_WORDS);
      req_tvalid <= 1'b0;

      while (chk.awaited.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (chk.errors == 0 && chk.awaited.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/smbi_pkg.sv
sv/smbi_ram.sv
sv/sorted_merge_by_insertion_top.sv
tb/sv/tb_top.sv
